// ===== src/ftbt_pkg.sv =====
package ftbt_pkg;

   localparam int WORD_W            = 64;
   localparam int REF_WIDTH_MAX_DEF = 32;
   localparam int SIZE_WIDTH_MAX_DEF = 8;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 32;
   localparam int MAX_RESULTS       = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAG_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFS = 2'd2;

   typedef struct packed {
      logic [31:0] init_table;
      logic [31:0] frag_total;
      logic [5:0]  start_offs;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } queue_head_type;

   // bit length of a 32-bit value
   function automatic logic [5:0] bit_len32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(i + 1);
      end
      return n;
   endfunction

   // bit length of a 16-bit value
   function automatic logic [4:0] bit_len16(input logic [15:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) n = 5'(i + 1);
      end
      return n;
   endfunction

endpackage

// ===== src/fragment_tree_bit_transcoder_unit.sv =====
// Re-encodes a stream of 64-bit words that holds preorder fragment trees. The
// three configuration registers are latched by the first word after reset; the
// low start offset bits of that word pass through as header. An intake queue of
// two words decouples the port from the parser, and a single output register
// holds a finished word, so a new word can be taken while a result waits. The
// parser takes the unary size bits one at a time, stop bit included, and each
// reference field in two steps (read, then pack). Around the parse steps a word
// passes queue pop, append to the bit buffer, release of a finished word that
// is still held and, at job end, a flush word. A stalled result side holds the
// parser back; at most three result words come from one input word.
module fragment_tree_bit_transcoder_unit #(
   parameter int REF_WIDTH_MAX  = ftbt_pkg::REF_WIDTH_MAX_DEF,
   parameter int SIZE_WIDTH_MAX = ftbt_pkg::SIZE_WIDTH_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ftbt_pkg::WORD_W-1:0]       req_in_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ftbt_pkg::WORD_W-1:0]       rsp_out_word,
   output logic                              rsp_is_last,
   output logic                              rsp_too_wide,
   input  logic                              csr_wr_en,
   input  logic [ftbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ftbt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ftbt_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_INIT_TABLE: cfg_in.init_table = csr_wdata;
            CSR_FRAG_TOTAL: cfg_in.frag_total = csr_wdata;
            CSR_START_OFFS: cfg_in.start_offs = csr_wdata[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_table <= 32'd1;
         cfg_ff.frag_total <= 32'd0;
         cfg_ff.start_offs <= 6'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ftbt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_word (req_in_word),
      .head        (head),
      .pop         (pop)
   );

   ftbt_back #(
      .REF_WIDTH_MAX  (REF_WIDTH_MAX),
      .SIZE_WIDTH_MAX (SIZE_WIDTH_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_word (rsp_out_word),
      .rsp_is_last  (rsp_is_last),
      .rsp_too_wide (rsp_too_wide)
   );

endmodule

// ===== src/ftbt_front.sv =====
module ftbt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ftbt_pkg::WORD_W-1:0]   req_in_word,
   output ftbt_pkg::queue_head_type      head,
   input  logic                          pop
);
   import ftbt_pkg::*;

   logic [WORD_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;

   // two-entry word queue between intake and parser
   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign head.valid = (count_ff != 2'd0);
   assign head.word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= req_in_word;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/ftbt_back.sv =====
module ftbt_back #(
   parameter int REF_WIDTH_MAX  = ftbt_pkg::REF_WIDTH_MAX_DEF,
   parameter int SIZE_WIDTH_MAX = ftbt_pkg::SIZE_WIDTH_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ftbt_pkg::cfg_type             cfg,
   input  ftbt_pkg::queue_head_type      head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ftbt_pkg::WORD_W-1:0]   rsp_out_word,
   output logic                          rsp_is_last,
   output logic                          rsp_too_wide
);
   import ftbt_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DRAIN, S_PUT, S_APPEND, S_FLUSH} state_type;

   state_type     state_ff, state_in;
   logic          second_ff, second_in;
   logic [63:0]   word_ff, word_in;
   logic [127:0]  buf_ff, buf_in;
   logic [7:0]    fill_ff, fill_in;
   logic [63:0]   acc_ff, acc_in;
   logic [5:0]    ofill_ff, ofill_in;
   logic [31:0]   tbl_ff, tbl_in;
   logic [31:0]   frag_ff, frag_in;
   logic [31:0]   pend_ff, pend_in;
   logic [15:0]   unary_ff, unary_in;
   logic          phase_ff, phase_in;
   logic          first_ff, first_in;
   logic          done_ff, done_in;
   logic          err_ff, err_in;
   logic [1:0]    n_ff, n_in;
   logic          hold_valid_ff, hold_valid_in;
   logic [63:0]   hold_word_ff, hold_word_in;
   logic          hold_last_ff, hold_last_in;
   logic          hold_err_ff, hold_err_in;
   logic [63:0]   code_ff, code_in;
   logic [6:0]    cw_ff, cw_in;
   logic [15:0]   sz_ff, sz_in;
   logic          out_valid_ff, out_valid_in;
   logic [63:0]   out_word_ff, out_word_in;
   logic          out_last_ff, out_last_in;
   logic          out_err_ff, out_err_in;

   logic          out_free;
   logic [31:0]   maxref, ref_val, rev;
   logic [5:0]    rw;
   logic [63:0]   rmask;
   logic [4:0]    s;
   logic [15:0]   low;
   logic [127:0]  sh;
   logic [7:0]    total;
   logic [32:0]   psum;
   logic [31:0]   pend_new, frag_new;
   logic [15:0]   un_eff;
   logic          hv_after;
   logic [5:0]    of_after;

   assign out_free     = !out_valid_ff || rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_out_word = out_word_ff;
   assign rsp_is_last  = out_last_ff;
   assign rsp_too_wide = out_err_ff;

   // reference field geometry from the current table size
   assign maxref  = tbl_ff - 32'd1;
   assign rw      = bit_len32(maxref);
   assign rmask   = (64'd1 << rw) - 64'd1;
   assign ref_val = buf_ff[31:0] & rmask[31:0];
   assign rev     = (maxref - ref_val) & rmask[31:0];
   assign s       = bit_len16(unary_ff);
   assign low     = unary_ff & ((16'd1 << (s - 5'd1)) - 16'd1);
   // output packing
   assign sh      = {64'd0, code_ff} << ofill_ff;
   assign total   = {2'b0, ofill_ff} + {1'b0, cw_ff};
   assign psum    = {1'b0, pend_ff - 32'd1} + {17'd0, sz_ff};

   always_comb begin
      state_in = state_ff; second_in = second_ff; word_in = word_ff;
      buf_in = buf_ff; fill_in = fill_ff; acc_in = acc_ff; ofill_in = ofill_ff;
      tbl_in = tbl_ff; frag_in = frag_ff; pend_in = pend_ff; unary_in = unary_ff;
      phase_in = phase_ff; first_in = first_ff; done_in = done_ff; err_in = err_ff;
      n_in = n_ff; hold_valid_in = hold_valid_ff; hold_word_in = hold_word_ff;
      hold_last_in = hold_last_ff; hold_err_in = hold_err_ff;
      code_in = code_ff; cw_in = cw_ff; sz_in = sz_ff;
      out_valid_in = out_valid_ff; out_word_in = out_word_ff;
      out_last_in = out_last_ff; out_err_in = out_err_ff;
      pop = 1'b0;
      un_eff = unary_ff; pend_new = pend_ff; frag_new = frag_ff;
      hv_after = hold_valid_ff; of_after = ofill_ff;

      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;

      case (state_ff)
         // take the next word from the queue and open a step
         S_IDLE: begin
            if (head.valid) begin
               pop  = 1'b1;
               n_in = 2'd0;
               if (done_ff) begin
                  state_in = S_FLUSH;
               end else if (!first_ff) begin
                  first_in  = 1'b1;
                  tbl_in    = cfg.init_table;
                  frag_in   = cfg.frag_total;
                  buf_in    = {64'd0, head.word} >> cfg.start_offs;
                  fill_in   = 8'd64 - {2'b0, cfg.start_offs};
                  acc_in    = head.word & ((64'd1 << cfg.start_offs) - 64'd1);
                  ofill_in  = cfg.start_offs;
                  second_in = 1'b1;
                  state_in  = S_DRAIN;
               end else begin
                  word_in   = head.word;
                  second_in = 1'b0;
                  state_in  = S_DRAIN;
               end
            end
         end

         // one parse step: a unary bit, or a reference field
         S_DRAIN: begin
            if (done_ff || n_ff == 2'd3) begin
               state_in = second_ff ? S_FLUSH : S_APPEND;
            end else if (!phase_ff) begin
               if (pend_ff == 32'd0 && frag_ff == 32'd0) begin
                  done_in = 1'b1;
                  if (ofill_ff == 6'd0 && hold_valid_ff) hold_last_in = 1'b1;
                  state_in = second_ff ? S_FLUSH : S_APPEND;
               end else begin
                  if (pend_ff == 32'd0) begin
                     pend_in = 32'd1;
                     un_eff  = 16'd1;
                  end
                  unary_in = un_eff;
                  if (fill_ff == 8'd0) begin
                     state_in = second_ff ? S_FLUSH : S_APPEND;
                  end else begin
                     buf_in  = buf_ff >> 1;
                     fill_in = fill_ff - 8'd1;
                     if (buf_ff[0]) begin
                        if (un_eff == 16'hFFFF) err_in = 1'b1;
                        else unary_in = un_eff + 16'd1;
                     end else begin
                        if ((un_eff >> SIZE_WIDTH_MAX) != 16'd0) err_in = 1'b1;
                        phase_in = 1'b1;
                     end
                  end
               end
            end else begin
               if (fill_ff < {2'b0, rw}) begin
                  state_in = second_ff ? S_FLUSH : S_APPEND;
               end else begin
                  if (rw > 6'(REF_WIDTH_MAX)) err_in = 1'b1;
                  buf_in  = buf_ff >> rw;
                  fill_in = fill_ff - {2'b0, rw};
                  sz_in   = unary_ff;
                  if (unary_ff == 16'd0) begin
                     code_in = ({32'd0, rev} << 1) | 64'd1;
                     cw_in   = {1'b0, rw} + 7'd1;
                  end else begin
                     code_in = ({32'd0, rev} << {s, 1'b0}) | ({48'd0, low} << (s + 5'd1))
                               | (64'd1 << s);
                     cw_in   = {1'b0, rw} + {1'b0, s, 1'b0};
                  end
                  state_in = S_PUT;
               end
            end
         end

         // pack the code, pass on a finished word, update the tree counters
         S_PUT: begin
            if (!(total >= 8'd64 && hold_valid_ff && !out_free)) begin
               if (total >= 8'd64) begin
                  if (hold_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_word_in  = hold_word_ff;
                     out_last_in  = hold_last_ff;
                     out_err_in   = hold_err_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_word_in  = acc_ff | sh[63:0];
                  hold_last_in  = 1'b0;
                  hold_err_in   = err_ff;
                  n_in          = n_ff + 2'd1;
                  acc_in        = sh[127:64];
                  of_after      = 6'(total - 8'd64);
                  hv_after      = 1'b1;
               end else begin
                  acc_in   = acc_ff | sh[63:0];
                  of_after = total[5:0];
               end
               ofill_in = of_after;
               pend_new = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
               pend_in  = pend_new;
               phase_in = 1'b0;
               unary_in = 16'd0;
               if (pend_new == 32'd0) begin
                  if (tbl_ff != 32'hFFFF_FFFF) tbl_in = tbl_ff + 32'd1;
                  if (frag_ff != 32'd0) frag_new = frag_ff - 32'd1;
                  frag_in = frag_new;
                  if (frag_new == 32'd0) begin
                     done_in = 1'b1;
                     if (of_after == 6'd0 && hv_after) hold_last_in = 1'b1;
                  end
               end
               state_in = S_DRAIN;
            end
         end

         // append the word of this step to the bit buffer
         S_APPEND: begin
            if (!done_ff) begin
               if (fill_ff <= 8'd64) begin
                  buf_in  = buf_ff | ({64'd0, word_ff} << fill_ff);
                  fill_in = fill_ff + 8'd64;
               end else begin
                  err_in = 1'b1;
               end
            end
            second_in = 1'b1;
            state_in  = S_DRAIN;
         end

         // release the held word, then any flush word owed
         S_FLUSH: begin
            if (hold_valid_ff) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_word_in   = hold_word_ff;
                  out_last_in   = hold_last_ff;
                  out_err_in    = hold_err_ff;
                  hold_valid_in = 1'b0;
               end
            end else if (done_ff && ofill_ff != 6'd0 && n_ff != 2'd3) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_word_in  = acc_ff;
                  out_last_in  = 1'b1;
                  out_err_in   = err_ff;
                  acc_in       = 64'd0;
                  ofill_in     = 6'd0;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in; buf_ff <= buf_in; acc_ff <= acc_in;
      hold_word_ff <= hold_word_in; hold_last_ff <= hold_last_in; hold_err_ff <= hold_err_in;
      code_ff <= code_in; cw_ff <= cw_in; sz_ff <= sz_in;
      out_word_ff <= out_word_in; out_last_ff <= out_last_in; out_err_ff <= out_err_in;
      if (reset) begin
         state_ff <= S_IDLE; second_ff <= 1'b0; fill_ff <= 8'd0; ofill_ff <= 6'd0;
         tbl_ff <= 32'd1; frag_ff <= 32'd0; pend_ff <= 32'd0; unary_ff <= 16'd0;
         phase_ff <= 1'b0; first_ff <= 1'b0; done_ff <= 1'b0; err_ff <= 1'b0;
         n_ff <= 2'd0; hold_valid_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; second_ff <= second_in; fill_ff <= fill_in;
         ofill_ff <= ofill_in; tbl_ff <= tbl_in; frag_ff <= frag_in; pend_ff <= pend_in;
         unary_ff <= unary_in; phase_ff <= phase_in; first_ff <= first_in;
         done_ff <= done_in; err_ff <= err_in; n_ff <= n_in;
         hold_valid_ff <= hold_valid_in; out_valid_ff <= out_valid_in;
      end
   end

   // buffer never holds more than two words
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 8'd128) else $error("bit buffer overfilled");
   // a held word never outlives its step
   a_hold_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff) else $error("held word left behind");
   // job ends only with no tree work left
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (pend_ff == 32'd0 && frag_ff == 32'd0)) else $error("job ended early");
   // a word is never emitted without a free output slot
   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_word_ff == $past(out_word_ff)))
      else $error("output overwritten");

endmodule
